FILE: hw/rtl/hmtv_pkg.sv
package hmtv_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_GRID_SIDE    = 3'd0,
        REG_ROW_SCALE    = 3'd1,
        REG_COLUMN_SCALE = 3'd2,
        REG_HEIGHT_SCALE = 3'd3,
        REG_INV_TEX_SPAN = 3'd4
    } cfg_reg_t;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic       cmd;
        logic [7:0] height;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         grid_col;
        logic [7:0]         grid_row;
        logic [23:0]        pos_x;
        logic [15:0]        pos_y;
        logic [23:0]        pos_z;
        logic [23:0]        tex_u;
        logic [23:0]        tex_v;
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] norm_x;
        logic signed [15:0] norm_y;
        logic signed [15:0] norm_z;
    } normal_t;

endpackage

FILE: hw/rtl/hmtv_line_store.sv
module hmtv_line_store #(
    parameter int DEPTH = 256,
    parameter int AW = 8
) (
    input  logic          clk,
    input  logic [AW-1:0] rd_addr_c,
    input  logic [AW-1:0] rd_addr_r,
    input  logic          prev_we,
    input  logic [AW-1:0] prev_waddr,
    input  logic [7:0]    prev_wdata,
    input  logic          pp_we,
    input  logic [AW-1:0] pp_waddr,
    input  logic [7:0]    pp_wdata,
    output logic [7:0]    center,
    output logic [7:0]    right,
    output logic [7:0]    up
);

    logic [7:0] prev_mem [DEPTH];
    logic [7:0] pp_mem [DEPTH];

    // read-before-write: a same-cycle write returns the old entry
    always_ff @(posedge clk)
    begin
        center <= prev_mem[rd_addr_c];
        right <= prev_mem[rd_addr_r];
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        up <= pp_mem[rd_addr_c];
        if (pp_we)
        begin
            pp_mem[pp_waddr] <= pp_wdata;
        end
    end

endmodule

FILE: hw/rtl/hmtv_norm_unit.sv
module hmtv_norm_unit (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic signed [8:0]   dx,
    input  logic signed [8:0]   dy,
    output logic                done,
    output hmtv_pkg::normal_t   normal
);

    typedef enum logic [2:0] {
        N_IDLE,
        N_LEN,
        N_DIV,
        N_SQRT,
        N_FIN,
        N_DONE
    } nstate_t;

    nstate_t             state_reg;
    logic [1:0]          comp_reg;
    logic [4:0]          cnt_reg;
    logic [15:0]         sqx_reg;
    logic [15:0]         sqy_reg;
    logic                negx_reg;
    logic                negy_reg;
    logic [16:0]         len2_reg;
    logic [16:0]         rem_reg;
    logic                lsb_reg;
    logic [30:0]         quo_reg;
    logic [30:0]         q_reg;
    logic [30:0]         res_reg;
    hmtv_pkg::normal_t   normal_reg;

    logic [8:0]          ax;
    logic [8:0]          ay;
    logic [17:0]         rem_sh;
    logic [30:0]         bit_val;
    logic [30:0]         trial;
    logic [16:0]         rnd;
    logic [15:0]         mag;
    logic                neg;
    logic [15:0]         a2_next;

    assign ax = dx[8] ? 9'(-dx) : 9'(dx);
    assign ay = dy[8] ? 9'(-dy) : 9'(dy);
    assign rem_sh = {rem_reg, (cnt_reg == 5'd0) ? lsb_reg : 1'b0};
    assign bit_val = 31'(1) << {cnt_reg[3:0], 1'b0};
    assign trial = res_reg + bit_val;
    assign rnd = 17'(res_reg) + 17'd1;
    assign mag = rnd[16:1];

    always_comb
    begin
        case (comp_reg)
            2'd0: neg = negx_reg;
            2'd1: neg = negy_reg;
            default: neg = 1'b0;
        endcase
        case (comp_reg)
            2'd0: a2_next = sqy_reg;
            default: a2_next = 16'd4;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= N_IDLE;
        end
        else
        begin
            unique case (state_reg)
                N_IDLE, N_DONE:
                begin
                    if (start)
                    begin
                        sqx_reg <= 16'(ax * ax);
                        sqy_reg <= 16'(ay * ay);
                        negx_reg <= dx[8];
                        negy_reg <= dy[8];
                        state_reg <= N_LEN;
                    end
                end
                N_LEN:
                begin
                    len2_reg <= 17'(sqx_reg) + 17'(sqy_reg) + 17'd4;
                    rem_reg <= {2'b00, sqx_reg[15:1]};
                    lsb_reg <= sqx_reg[0];
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    comp_reg <= 2'd0;
                    state_reg <= N_DIV;
                end
                N_DIV:
                begin
                    // one quotient bit per cycle, 31 bits
                    if (rem_sh >= 18'(len2_reg))
                    begin
                        rem_reg <= 17'(rem_sh - 18'(len2_reg));
                        quo_reg <= {quo_reg[29:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rem_sh[16:0];
                        quo_reg <= {quo_reg[29:0], 1'b0};
                    end
                    if (cnt_reg == 5'd30)
                    begin
                        cnt_reg <= 5'd31;
                        state_reg <= N_SQRT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 5'd1;
                    end
                end
                N_SQRT:
                begin
                    if (cnt_reg == 5'd31)
                    begin
                        q_reg <= quo_reg;
                        res_reg <= '0;
                        cnt_reg <= 5'd15;
                    end
                    else
                    begin
                        if (q_reg >= trial)
                        begin
                            q_reg <= q_reg - trial;
                            res_reg <= (res_reg >> 1) + bit_val;
                        end
                        else
                        begin
                            res_reg <= res_reg >> 1;
                        end
                        if (cnt_reg == 5'd0)
                        begin
                            state_reg <= N_FIN;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg - 5'd1;
                        end
                    end
                end
                N_FIN:
                begin
                    case (comp_reg)
                        2'd0: normal_reg.norm_x <= neg ? 16'(-mag) : mag;
                        2'd1: normal_reg.norm_y <= neg ? 16'(-mag) : mag;
                        default: normal_reg.norm_z <= mag;
                    endcase
                    rem_reg <= {2'b00, a2_next[15:1]};
                    lsb_reg <= a2_next[0];
                    quo_reg <= '0;
                    cnt_reg <= '0;
                    comp_reg <= comp_reg + 2'd1;
                    state_reg <= (comp_reg == 2'd2) ? N_DONE : N_DIV;
                end
                default:
                begin
                    state_reg <= N_IDLE;
                end
            endcase
        end
    end

    // SQRT entry cycle uses cnt 31 as load marker; iterations then run 15 down to 0,
    // bit 4^cnt. The quotient never exceeds 2^30, so 4^15 is the top bit needed.
    assign done = (state_reg == N_DONE);
    assign normal = normal_reg;

endmodule

FILE: hw/rtl/heightmap_terrain_vertex_gen.sv
// Heightmap terrain vertex generator. Height bytes come in raster order, one
// item per sample; each vertex leaves one row late (once its lower neighbor
// has arrived) with grid indices, scaled position, texture coordinates and a
// Q1.14 unit normal normalize(left-right, down-up, 2), rounded to nearest.
// Rows 0..side-2 are emitted by sample items; a final row of side flush items
// (cmd = 1) emits the last row and ends the frame, with last set on its final
// vertex. Samples on row zero, samples after a full grid and flush items sent
// early produce no vertex and do not stall the input. An item that emits a
// vertex stalls the input until the vertex is registered; most of that time
// goes to the shared normal unit, which runs a 31-step restoring divider and
// a square root of a load step and 16 steps once per component, three
// components per vertex. A new item is taken while a finished vertex still
// waits in the output register. Line stores are not cleared at reset.
module heightmap_terrain_vertex_gen #(
    parameter int MAX_SIDE = 256
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  hmtv_pkg::in_item_t                   in_item,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output hmtv_pkg::out_item_t                  out_item,
    input  logic                                 cfg_we,
    input  logic [hmtv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [hmtv_pkg::CFG_DATA_W-1:0]      cfg_data
);

    localparam int AW = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;
    localparam int SW = (AW + 1 > 9) ? AW + 1 : 9;
    localparam int PW = SW + 16;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_NORM,
        S_DONE
    } state_t;

    state_t              state_reg;
    logic [8:0]          grid_side_reg;
    logic [15:0]         row_scale_reg;
    logic [15:0]         column_scale_reg;
    logic [15:0]         height_scale_reg;
    logic [15:0]         inv_tex_span_reg;
    logic [AW-1:0]       col_cnt_reg;
    logic [SW-1:0]       row_cnt_reg;
    logic [7:0]          left_hold_reg;

    // vertex under work
    logic [AW-1:0]       c_reg;
    logic [SW-1:0]       r_reg;
    logic                row_end_reg;
    logic                is_sample_reg;
    logic [7:0]          down_reg;
    logic                last_reg;
    logic                norm_start;
    logic [23:0]         pos_x_reg;
    logic [15:0]         pos_y_reg;
    logic [23:0]         pos_z_reg;
    logic [23:0]         tex_u_reg;
    logic [23:0]         tex_v_reg;

    logic                out_valid_reg;
    hmtv_pkg::out_item_t out_item_reg;

    logic [SW-1:0]       side;
    logic [SW-1:0]       c_ext;
    logic                row_end;
    logic                accept;
    logic                full;
    logic                prev_we;
    logic [AW-1:0]       rd_addr_r;
    logic [7:0]          center;
    logic [7:0]          right_raw;
    logic [7:0]          up_raw;
    logic [7:0]          left_v;
    logic [7:0]          right_v;
    logic [7:0]          up_v;
    logic signed [8:0]   dx;
    logic signed [8:0]   dy;
    logic                norm_done;
    hmtv_pkg::normal_t   normal;
    logic [PW-1:0]       prod_x;
    logic [PW-1:0]       prod_z;
    logic [PW-1:0]       prod_u;
    logic [PW-1:0]       prod_v;
    logic [23:0]         prod_y;
    logic                out_free;

    // grid side clamped to [2, MAX_SIDE]
    always_comb
    begin
        if (SW'(grid_side_reg) < SW'(2))
        begin
            side = SW'(2);
        end
        else if (SW'(grid_side_reg) > SW'(MAX_SIDE))
        begin
            side = SW'(MAX_SIDE);
        end
        else
        begin
            side = SW'(grid_side_reg);
        end
    end

    assign c_ext = SW'(col_cnt_reg);
    assign row_end = (c_ext + SW'(1)) >= side;
    assign full = row_cnt_reg >= side;
    assign in_stall = (state_reg != S_IDLE);
    assign accept = in_valid && !in_stall;
    assign prev_we = accept && (in_item.cmd == hmtv_pkg::CMD_SAMPLE) && !full;
    assign rd_addr_r = col_cnt_reg + AW'(1);

    hmtv_line_store #(
        .DEPTH(MAX_SIDE),
        .AW(AW)
    ) u_store (
        .clk        (clk),
        .rd_addr_c  (col_cnt_reg),
        .rd_addr_r  (rd_addr_r),
        .prev_we    (prev_we),
        .prev_waddr (col_cnt_reg),
        .prev_wdata (in_item.height),
        .pp_we      ((state_reg == S_READ) && is_sample_reg),
        .pp_waddr   (c_reg),
        .pp_wdata   (center),
        .center     (center),
        .right      (right_raw),
        .up         (up_raw)
    );

    // neighbors outside the grid read as zero
    assign left_v = (c_reg != '0) ? left_hold_reg : 8'd0;
    assign right_v = row_end_reg ? 8'd0 : right_raw;
    assign up_v = (r_reg != '0) ? up_raw : 8'd0;
    assign dx = $signed({1'b0, left_v}) - $signed({1'b0, right_v});
    assign dy = $signed({1'b0, down_reg}) - $signed({1'b0, up_v});

    // the normal unit takes dx/dy while store data and the left hold are current
    assign norm_start = (state_reg == S_READ);

    hmtv_norm_unit u_norm (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (norm_start),
        .dx     (dx),
        .dy     (dy),
        .done   (norm_done),
        .normal (normal)
    );

    assign prod_x = PW'(r_reg) * PW'(row_scale_reg);
    assign prod_z = PW'(c_reg) * PW'(column_scale_reg);
    assign prod_u = PW'(c_reg) * PW'(inv_tex_span_reg);
    assign prod_v = PW'(r_reg) * PW'(inv_tex_span_reg);
    assign prod_y = 24'(center) * 24'(height_scale_reg);
    assign out_free = !out_valid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            grid_side_reg <= 9'd256;
            row_scale_reg <= 16'd256;
            column_scale_reg <= 16'd256;
            height_scale_reg <= 16'd256;
            inv_tex_span_reg <= 16'd8192;
            col_cnt_reg <= '0;
            row_cnt_reg <= '0;
            left_hold_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    hmtv_pkg::REG_GRID_SIDE:    grid_side_reg <= cfg_data[8:0];
                    hmtv_pkg::REG_ROW_SCALE:    row_scale_reg <= cfg_data;
                    hmtv_pkg::REG_COLUMN_SCALE: column_scale_reg <= cfg_data;
                    hmtv_pkg::REG_HEIGHT_SCALE: height_scale_reg <= cfg_data;
                    hmtv_pkg::REG_INV_TEX_SPAN: inv_tex_span_reg <= cfg_data;
                    default: ;
                endcase
            end

            if ((state_reg == S_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        c_reg <= col_cnt_reg;
                        r_reg <= row_cnt_reg - SW'(1);
                        row_end_reg <= row_end;
                        if (in_item.cmd == hmtv_pkg::CMD_SAMPLE)
                        begin
                            if (!full)
                            begin
                                is_sample_reg <= 1'b1;
                                down_reg <= in_item.height;
                                last_reg <= 1'b0;
                                if (row_cnt_reg != '0)
                                begin
                                    state_reg <= S_READ;
                                end
                                if (row_end)
                                begin
                                    col_cnt_reg <= '0;
                                    row_cnt_reg <= row_cnt_reg + SW'(1);
                                end
                                else
                                begin
                                    col_cnt_reg <= col_cnt_reg + AW'(1);
                                end
                            end
                        end
                        else if (full)
                        begin
                            is_sample_reg <= 1'b0;
                            down_reg <= 8'd0;
                            last_reg <= row_end;
                            state_reg <= S_READ;
                            if (row_end)
                            begin
                                col_cnt_reg <= '0;
                                row_cnt_reg <= '0;
                            end
                            else
                            begin
                                col_cnt_reg <= col_cnt_reg + AW'(1);
                            end
                        end
                    end
                end
                S_READ:
                begin
                    // store data is valid here
                    left_hold_reg <= center;
                    pos_x_reg <= prod_x[23:0];
                    pos_z_reg <= prod_z[23:0];
                    tex_u_reg <= prod_u[23:0];
                    tex_v_reg <= prod_v[23:0];
                    pos_y_reg <= prod_y[23:8];
                    state_reg <= S_NORM;
                end
                S_NORM:
                begin
                    if (norm_done)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    if (out_free)
                    begin
                        out_item_reg.grid_col <= 8'(c_reg);
                        out_item_reg.grid_row <= r_reg[7:0];
                        out_item_reg.pos_x <= pos_x_reg;
                        out_item_reg.pos_y <= pos_y_reg;
                        out_item_reg.pos_z <= pos_z_reg;
                        out_item_reg.tex_u <= tex_u_reg;
                        out_item_reg.tex_v <= tex_v_reg;
                        out_item_reg.norm_x <= normal.norm_x;
                        out_item_reg.norm_y <= normal.norm_y;
                        out_item_reg.norm_z <= normal.norm_z;
                        out_item_reg.last <= last_reg;
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item = out_item_reg;

endmodule

FILE: tb/sv/heightmap_terrain_vertex_gen_tb.sv
`timescale 1ns / 1ps

module heightmap_terrain_vertex_gen_tb;

    // Generous ceiling on simulated cycles, covering every vertex plus stalls.
    localparam longint CYCLE_LIMIT = 4_000_000;
    // Quiet time before a register write or the final verdict.
    localparam int DRAIN_CYCLES = 400;
    localparam int SIDE_CAP = 256;

    // Vertex scoreboard: a shadow of the generator state, the registers and
    // the queue of vertices still owed by the block.
    class vertex_scoreboard;
        int unsigned side_reg;
        int unsigned row_scale;
        int unsigned col_scale;
        int unsigned hgt_scale;
        int unsigned tex_recip;
        byte unsigned cur_row[SIDE_CAP];
        byte unsigned old_row[SIDE_CAP];
        int unsigned col_cnt;
        int unsigned row_cnt;
        byte unsigned left_val;
        hmtv_pkg::out_item_t pending_vertices[$];
        int errors;

        function new();
            side_reg = 256;
            row_scale = 256;
            col_scale = 256;
            hgt_scale = 256;
            tex_recip = 8192;
            col_cnt = 0;
            row_cnt = 0;
            left_val = 0;
            errors = 0;
            foreach (cur_row[i])
            begin
                cur_row[i] = 0;
                old_row[i] = 0;
            end
        endfunction

        function void set_reg(hmtv_pkg::cfg_reg_t idx, int unsigned val);
            case (idx)
                hmtv_pkg::REG_GRID_SIDE:    side_reg = val & 9'h1FF;
                hmtv_pkg::REG_ROW_SCALE:    row_scale = val & 16'hFFFF;
                hmtv_pkg::REG_COLUMN_SCALE: col_scale = val & 16'hFFFF;
                hmtv_pkg::REG_HEIGHT_SCALE: hgt_scale = val & 16'hFFFF;
                hmtv_pkg::REG_INV_TEX_SPAN: tex_recip = val & 16'hFFFF;
                default: ;
            endcase
        endfunction

        function longint unsigned int_sqrt(longint unsigned q);
            longint unsigned res;
            longint unsigned bits;
            res = 0;
            bits = 64'd1 << 62;
            while (bits > q)
                bits >>= 2;
            while (bits != 0)
            begin
                if (q >= res + bits)
                begin
                    q -= res + bits;
                    res = (res >> 1) + bits;
                end
                else
                    res >>= 1;
                bits >>= 2;
            end
            return res;
        endfunction

        // round(16384 * v / sqrt(len2)), halves away from zero
        function logic [15:0] unit_part(int v, longint unsigned len2);
            longint unsigned mag;
            longint unsigned q;
            logic [15:0] r;
            mag = (v < 0) ? -v : v;
            q = ((64'd1 << 30) * mag * mag) / len2;
            r = 16'((int_sqrt(q) + 1) >> 1);
            return (v < 0) ? -r : r;
        endfunction

        function hmtv_pkg::out_item_t make_vertex(int unsigned r, int unsigned c,
                                                  int unsigned ctr,
                                                  int unsigned lft, int unsigned rgt,
                                                  int unsigned up, int unsigned dn, bit fin);
            hmtv_pkg::out_item_t v;
            int dx;
            int dy;
            longint unsigned len2;
            dx = int'(lft) - int'(rgt);
            dy = int'(dn) - int'(up);
            len2 = longint'(dx * dx + dy * dy + 4);
            v.grid_col = 8'(c);
            v.grid_row = 8'(r);
            v.pos_x = 24'(longint'(r) * row_scale);
            v.pos_y = 16'((longint'(ctr) * hgt_scale) >> 8);
            v.pos_z = 24'(longint'(c) * col_scale);
            v.tex_u = 24'(longint'(c) * tex_recip);
            v.tex_v = 24'(longint'(r) * tex_recip);
            v.norm_x = unit_part(dx, len2);
            v.norm_y = unit_part(dy, len2);
            v.norm_z = unit_part(2, len2);
            v.last = fin;
            return v;
        endfunction

        function void note_input(hmtv_pkg::in_item_t it);
            int unsigned s;
            int unsigned c;
            int unsigned r;
            int unsigned ctr;
            int unsigned lft;
            int unsigned rgt;
            int unsigned up;
            bit row_end;
            s = (side_reg < 2) ? 2 : (side_reg > SIDE_CAP) ? SIDE_CAP : side_reg;
            c = (col_cnt >= SIDE_CAP) ? SIDE_CAP - 1 : col_cnt;
            row_end = (c + 1 >= s);
            if (it.cmd == hmtv_pkg::CMD_SAMPLE && row_cnt >= s)
                return;     // grid already full
            if (it.cmd == hmtv_pkg::CMD_FLUSH && row_cnt < s)
                return;     // flush sent early
            if (row_cnt != 0)
            begin
                r = row_cnt - 1;
                ctr = cur_row[c];
                lft = (c != 0) ? left_val : 0;
                rgt = row_end ? 0 : cur_row[c + 1];
                up = (r != 0) ? old_row[c] : 0;
                if (it.cmd == hmtv_pkg::CMD_SAMPLE)
                begin
                    pending_vertices = {pending_vertices,
                                        make_vertex(r, c, ctr, lft, rgt, up,
                                                    it.height, 1'b0)};
                    old_row[c] = ctr;
                end
                else
                    pending_vertices = {pending_vertices,
                                        make_vertex(r, c, ctr, lft, rgt, up, 0,
                                                    row_end)};
                left_val = ctr;
            end
            if (it.cmd == hmtv_pkg::CMD_SAMPLE)
                cur_row[c] = it.height;
            if (row_end)
            begin
                col_cnt = 0;
                row_cnt = (it.cmd == hmtv_pkg::CMD_SAMPLE) ? row_cnt + 1 : 0;
            end
            else
                col_cnt = c + 1;
        endfunction

        function void cmp(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_vertex(hmtv_pkg::out_item_t act);
            hmtv_pkg::out_item_t e;
            if (pending_vertices.size() == 0)
            begin
                $error("unexpected vertex row %0d col %0d", act.grid_row, act.grid_col);
                errors++;
                return;
            end
            e = pending_vertices.pop_front();
            cmp("grid_col", e.grid_col, act.grid_col);
            cmp("grid_row", e.grid_row, act.grid_row);
            cmp("pos_x", e.pos_x, act.pos_x);
            cmp("pos_y", e.pos_y, act.pos_y);
            cmp("pos_z", e.pos_z, act.pos_z);
            cmp("tex_u", e.tex_u, act.tex_u);
            cmp("tex_v", e.tex_v, act.tex_v);
            cmp("norm_x", 16'(e.norm_x), 16'(act.norm_x));
            cmp("norm_y", 16'(e.norm_y), 16'(act.norm_y));
            cmp("norm_z", 16'(e.norm_z), 16'(act.norm_z));
            cmp("last", e.last, act.last);
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    hmtv_pkg::in_item_t in_item;
    logic out_valid;
    logic out_stall;
    hmtv_pkg::out_item_t out_item;
    logic cfg_we;
    logic [hmtv_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [hmtv_pkg::CFG_DATA_W-1:0] cfg_data;

    vertex_scoreboard sb = new();
    longint cycles = 0;
    int idle_pct = 0;       // sender gap probability, percent
    int stall_pct = 0;      // receiver stall probability, percent
    int accepted = 0;

    heightmap_terrain_vertex_gen dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // Watchdog.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Receiver back-pressure.
    always @(posedge clk)
        if (rst_n)
            out_stall <= ($urandom_range(99) < stall_pct);

    // Handshake monitor: values read here are the ones from before the edge.
    always @(posedge clk)
    begin
        if (rst_n && in_valid && !in_stall)
        begin
            sb.note_input(in_item);
            accepted++;
        end
        if (rst_n && out_valid && !out_stall)
            sb.check_vertex(out_item);
    end

    // Let all owed vertices arrive, then give the block time to go quiet.
    task automatic wait_drained();
        while (sb.pending_vertices.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(hmtv_pkg::cfg_reg_t idx, int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= hmtv_pkg::CFG_DATA_W'(val);
        @(posedge clk);
        sb.set_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Drive one item; valid stays up across back-to-back items.
    task automatic send_item(logic cmd, logic [7:0] hgt);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 1'b0;
            in_item <= hmtv_pkg::in_item_t'($urandom);
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_item.cmd <= cmd;
        in_item.height <= hgt;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Full frame of random heights; mode 1 uses only extreme heights.
    task automatic send_frame(int unsigned s, int mode, bit noise);
        int unsigned h;
        for (int i = 0; i < s * s; i++)
        begin
            if (noise && $urandom_range(19) == 0)
                send_item(hmtv_pkg::CMD_FLUSH, 8'($urandom));     // early flush, ignored
            h = $urandom;
            if (mode == 1)
                h = ($urandom_range(1)) ? 8'hFF : 8'h00;
            send_item(hmtv_pkg::CMD_SAMPLE, 8'(h));
        end
        if (noise && $urandom_range(3) == 0)
            send_item(hmtv_pkg::CMD_SAMPLE, 8'($urandom));        // past full grid, ignored
        for (int i = 0; i < s; i++)
            send_item(hmtv_pkg::CMD_FLUSH, 8'($urandom));
    endtask

    function automatic int unsigned pick_scale();
        case ($urandom_range(5))
            0: return 0;
            1: return 16'hFFFF;
            default: return $urandom_range(16'hFFFF);
        endcase
    endfunction

    task automatic random_config();
        int unsigned side;
        side = ($urandom_range(9) == 0) ? $urandom_range(1) : $urandom_range(2, 12);
        wait_drained();
        write_reg(hmtv_pkg::REG_GRID_SIDE, side);
        if ($urandom_range(1)) write_reg(hmtv_pkg::REG_ROW_SCALE, pick_scale());
        if ($urandom_range(1)) write_reg(hmtv_pkg::REG_COLUMN_SCALE, pick_scale());
        if ($urandom_range(1)) write_reg(hmtv_pkg::REG_HEIGHT_SCALE, pick_scale());
        if ($urandom_range(1)) write_reg(hmtv_pkg::REG_INV_TEX_SPAN, pick_scale());
    endtask

    initial
    begin
        int goal;
        int unsigned side;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: side 0 clamps to 2, all scales at their top.
        write_reg(hmtv_pkg::REG_GRID_SIDE, 0);
        write_reg(hmtv_pkg::REG_ROW_SCALE, 16'hFFFF);
        write_reg(hmtv_pkg::REG_COLUMN_SCALE, 16'hFFFF);
        write_reg(hmtv_pkg::REG_HEIGHT_SCALE, 16'hFFFF);
        write_reg(hmtv_pkg::REG_INV_TEX_SPAN, 16'hFFFF);
        send_item(hmtv_pkg::CMD_FLUSH, 8'hFF);            // flush before any row: ignored
        send_item(hmtv_pkg::CMD_SAMPLE, 8'hFF);
        send_item(hmtv_pkg::CMD_SAMPLE, 8'h00);
        send_item(hmtv_pkg::CMD_SAMPLE, 8'h00);
        send_item(hmtv_pkg::CMD_SAMPLE, 8'hFF);
        send_item(hmtv_pkg::CMD_SAMPLE, 8'hAA);           // grid full: ignored
        send_item(hmtv_pkg::CMD_FLUSH, 8'h55);
        send_item(hmtv_pkg::CMD_FLUSH, 8'h00);
        stop_sending();
        // Side 3, zero scales, heights at both extremes.
        wait_drained();
        write_reg(hmtv_pkg::REG_GRID_SIDE, 3);
        write_reg(hmtv_pkg::REG_ROW_SCALE, 0);
        write_reg(hmtv_pkg::REG_COLUMN_SCALE, 0);
        write_reg(hmtv_pkg::REG_HEIGHT_SCALE, 0);
        write_reg(hmtv_pkg::REG_INV_TEX_SPAN, 0);
        send_frame(3, 1, 1'b0);
        stop_sending();
        wait_drained();
        write_reg(hmtv_pkg::REG_GRID_SIDE, 1);            // clamps to 2
        write_reg(hmtv_pkg::REG_HEIGHT_SCALE, 256);
        write_reg(hmtv_pkg::REG_ROW_SCALE, 256);
        send_frame(2, 1, 1'b0);
        stop_sending();

        // Random frames across the idling phases.
        for (int ph = 0; ph < 4; ph++)
        begin
            wait_drained();
            case (ph)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 81; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 81; end
                default: begin idle_pct = 21; stall_pct = 21; end
            endcase
            goal = accepted + 300;
            while (accepted < goal)
            begin
                random_config();
                side = (sb.side_reg < 2) ? 2 : sb.side_reg;
                send_frame(side, $urandom_range(3) == 0, 1'b1);
                stop_sending();
            end
        end

        // Widest grid: 511 clamps to 256. Two full rows give a row of
        // vertices; the frame is left open since no flush row follows.
        wait_drained();
        idle_pct = 5;
        stall_pct = 10;
        write_reg(hmtv_pkg::REG_GRID_SIDE, 511);
        write_reg(hmtv_pkg::REG_ROW_SCALE, 16'hFFFF);
        write_reg(hmtv_pkg::REG_COLUMN_SCALE, 16'hFFFF);
        write_reg(hmtv_pkg::REG_INV_TEX_SPAN, 16'hFFFF);
        for (int i = 0; i < 2 * SIDE_CAP; i++)
            send_item(hmtv_pkg::CMD_SAMPLE, 8'($urandom));
        send_item(hmtv_pkg::CMD_FLUSH, 8'h00);            // early flush, ignored
        stop_sending();

        wait_drained();
        if (sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule
